@@ rtl/tbgc_pkg.sv @@
// Shared types, constants and helpers for the two-button gesture classifier.
package tbgc_pkg;

  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned CFG_BITS  = 24;
  localparam int unsigned VOL_BITS  = 11;
  localparam int unsigned IDX_BITS  = 2;

  localparam logic [IDX_BITS-1:0] CFG_HOLD_TIME    = 2'd0;
  localparam logic [IDX_BITS-1:0] CFG_CLICK_WINDOW = 2'd1;
  localparam logic [IDX_BITS-1:0] CFG_ACTIVE_LOW   = 2'd2;

  localparam logic [CFG_BITS-1:0] HOLD_TIME_RST    = 24'd1000000;
  localparam logic [CFG_BITS-1:0] CLICK_WINDOW_RST = 24'd400000;

  // Volume levels, Q1.10
  localparam logic [VOL_BITS-1:0] VOL_TH_LOW  = 11'd205;
  localparam logic [VOL_BITS-1:0] VOL_TH_MID  = 11'd461;
  localparam logic [VOL_BITS-1:0] VOL_TH_HIGH = 11'd820;
  localparam logic [VOL_BITS-1:0] VOL_LVL_LOW  = 11'd307;
  localparam logic [VOL_BITS-1:0] VOL_LVL_MID  = 11'd614;
  localparam logic [VOL_BITS-1:0] VOL_LVL_FULL = 11'd1024;
  localparam logic [VOL_BITS-1:0] VOL_LVL_MIN  = 11'd102;

  localparam logic [1:0] CLICKS_ONE = 2'd1;
  localparam logic [1:0] CLICKS_TWO = 2'd2;

  typedef enum logic [2:0] {
    EV1_NONE   = 3'd0,
    EV1_HOLD   = 3'd1,
    EV1_DOUBLE = 3'd2,
    EV1_PAUSE  = 3'd3,
    EV1_RESUME = 3'd4
  } first_ev_e;

  typedef enum logic [1:0] {
    EV2_NONE      = 2'd0,
    EV2_LOOP      = 2'd1,
    EV2_NEXT_LIST = 2'd2,
    EV2_NEXT_SONG = 2'd3
  } second_ev_e;

  // Per-poll control handed to each button tracker
  typedef struct packed {
    logic                 step;
    logic                 pressed;
    logic [TIME_BITS-1:0] now;
    logic [CFG_BITS-1:0]  hold_time;
    logic [CFG_BITS-1:0]  click_window;
  } btn_ctl_t;

  function automatic logic [VOL_BITS-1:0] step_volume(input logic [VOL_BITS-1:0] v);
    logic [VOL_BITS-1:0] r;
    if (v < VOL_TH_LOW) r = VOL_LVL_LOW;
    else if (v < VOL_TH_MID) r = VOL_LVL_MID;
    else if (v < VOL_TH_HIGH) r = VOL_LVL_FULL;
    else r = VOL_LVL_MIN;
    return r;
  endfunction

endpackage

@@ rtl/tbgc_first_btn.sv @@
// Press tracker for the first button: hold, double click, pause/resume.
module tbgc_first_btn (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbgc_pkg::btn_ctl_t  ctl_i,
  input  logic                playing_i,
  output tbgc_pkg::first_ev_e event_o
);
  import tbgc_pkg::*;

  logic                 down_q, down_d;
  logic                 hold_q, hold_d;
  logic [1:0]           clicks_q, clicks_d;
  logic [TIME_BITS-1:0] press_time_q, press_time_d;
  logic [TIME_BITS-1:0] click_time_q, click_time_d;
  logic [TIME_BITS-1:0] press_elapsed, click_elapsed;
  logic [TIME_BITS-1:0] hold_ext, window_ext;
  logic                 clicked;
  first_ev_e            ev;

  assign press_elapsed = ctl_i.now - press_time_q;
  assign click_elapsed = ctl_i.now - click_time_q;
  assign hold_ext      = TIME_BITS'(ctl_i.hold_time);
  assign window_ext    = TIME_BITS'(ctl_i.click_window);

  always_comb begin
    down_d       = down_q;
    hold_d       = hold_q;
    clicks_d     = clicks_q;
    press_time_d = press_time_q;
    click_time_d = click_time_q;
    clicked      = 1'b0;
    ev           = EV1_NONE;
    if (ctl_i.pressed) begin
      if (!down_q) begin
        down_d       = 1'b1;
        press_time_d = ctl_i.now;
        hold_d       = 1'b0;
      end else if (!hold_q && (press_elapsed > hold_ext)) begin
        ev       = EV1_HOLD;
        hold_d   = 1'b1;
        clicks_d = '0;
      end
    end else begin
      if (down_q) begin
        // release exactly at hold time is not a click
        if (!hold_q && (press_elapsed < hold_ext)) begin
          clicks_d     = clicks_q + 2'd1;
          click_time_d = ctl_i.now;
          clicked      = 1'b1;
          if (clicks_d == CLICKS_TWO) begin
            ev       = EV1_DOUBLE;
            clicks_d = '0;
          end
        end
        down_d = 1'b0;
      end
      // a click taken this poll has zero elapsed time, never past the window
      if ((clicks_d == CLICKS_ONE) && !clicked && (click_elapsed > window_ext)) begin
        ev       = playing_i ? EV1_PAUSE : EV1_RESUME;
        clicks_d = '0;
      end
    end
  end

  assign event_o = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q       <= 1'b0;
      hold_q       <= 1'b0;
      clicks_q     <= '0;
      press_time_q <= '0;
      click_time_q <= '0;
    end else if (ctl_i.step) begin
      down_q       <= down_d;
      hold_q       <= hold_d;
      clicks_q     <= clicks_d;
      press_time_q <= press_time_d;
      click_time_q <= click_time_d;
    end
  end

endmodule

@@ rtl/tbgc_second_btn.sv @@
// Press tracker for the second button: loop toggle, next list, next song.
module tbgc_second_btn (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tbgc_pkg::btn_ctl_t   ctl_i,
  input  logic                 multi_i,
  output tbgc_pkg::second_ev_e event_o
);
  import tbgc_pkg::*;

  logic                 down_q, down_d;
  logic                 hold_q, hold_d;
  logic [1:0]           clicks_q, clicks_d;
  logic [TIME_BITS-1:0] press_time_q, press_time_d;
  logic [TIME_BITS-1:0] click_time_q, click_time_d;
  logic [TIME_BITS-1:0] press_elapsed, click_elapsed;
  logic [TIME_BITS-1:0] hold_ext, window_ext;
  logic                 clicked;
  second_ev_e           ev;

  assign press_elapsed = ctl_i.now - press_time_q;
  assign click_elapsed = ctl_i.now - click_time_q;
  assign hold_ext      = TIME_BITS'(ctl_i.hold_time);
  assign window_ext    = TIME_BITS'(ctl_i.click_window);

  always_comb begin
    down_d       = down_q;
    hold_d       = hold_q;
    clicks_d     = clicks_q;
    press_time_d = press_time_q;
    click_time_d = click_time_q;
    clicked      = 1'b0;
    ev           = EV2_NONE;
    if (ctl_i.pressed) begin
      if (!down_q) begin
        down_d       = 1'b1;
        press_time_d = ctl_i.now;
        hold_d       = 1'b0;
      end else if (!hold_q && (press_elapsed > hold_ext)) begin
        ev       = EV2_LOOP;
        hold_d   = 1'b1;
        clicks_d = '0;
      end
    end else begin
      if (down_q) begin
        if (!hold_q) begin
          if (multi_i) begin
            clicks_d     = clicks_q + 2'd1;
            click_time_d = ctl_i.now;
            clicked      = 1'b1;
            if (clicks_d == CLICKS_TWO) begin
              ev       = EV2_NEXT_LIST;
              clicks_d = '0;
            end
          end else begin
            ev       = EV2_NEXT_SONG;
            clicks_d = '0;
          end
        end
        down_d = 1'b0;
      end
      // pending click only resolves while in multi-list mode
      if (multi_i && (clicks_d == CLICKS_ONE) && !clicked &&
          (click_elapsed > window_ext)) begin
        ev       = EV2_NEXT_SONG;
        clicks_d = '0;
      end
    end
  end

  assign event_o = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q       <= 1'b0;
      hold_q       <= 1'b0;
      clicks_q     <= '0;
      press_time_q <= '0;
      click_time_q <= '0;
    end else if (ctl_i.step) begin
      down_q       <= down_d;
      hold_q       <= hold_d;
      clicks_q     <= clicks_d;
      press_time_q <= press_time_d;
      click_time_q <= click_time_d;
    end
  end

endmodule

@@ rtl/two_button_gesture_classifier_core.sv @@
// Two-button gesture classifier: one poll in, one classified result out per cycle
// while the output is not stalled. Each accepted poll is captured in an input
// register, classified by both button trackers and placed in a result register,
// so a poll can be accepted every cycle while results are taken. Throughput is one
// poll per cycle, limited only by the result register being taken downstream; the
// trackers' 48-bit elapsed-time subtract and compare sets the critical path.
// Configuration writes take effect on the next poll.
module two_button_gesture_classifier_core (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [tbgc_pkg::IDX_BITS-1:0]              cfg_idx_i,
  input  logic [tbgc_pkg::CFG_BITS-1:0]              cfg_data_i,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic                                       first_level_i,
  input  logic                                       second_level_i,
  input  logic [tbgc_pkg::TIME_BITS-1:0]             now_us_i,
  input  logic                                       is_playing_i,
  input  logic                                       multi_list_mode_i,
  input  logic                                       loop_now_i,
  input  logic [tbgc_pkg::VOL_BITS-1:0]              volume_now_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic [2:0]                                 first_event_o,
  output logic [1:0]                                 second_event_o,
  output logic [tbgc_pkg::VOL_BITS-1:0]              volume_next_o,
  output logic                                       loop_next_o
);
  import tbgc_pkg::*;

  // configuration
  logic [CFG_BITS-1:0] hold_time_q;
  logic [CFG_BITS-1:0] click_window_q;
  logic                active_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_time_q    <= HOLD_TIME_RST;
      click_window_q <= CLICK_WINDOW_RST;
      active_low_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HOLD_TIME:    hold_time_q    <= cfg_data_i;
        CFG_CLICK_WINDOW: click_window_q <= cfg_data_i;
        CFG_ACTIVE_LOW:   active_low_q   <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  // input register
  logic                 s1_valid_q;
  logic                 s1_first_lvl_q, s1_second_lvl_q;
  logic [TIME_BITS-1:0] s1_now_q;
  logic                 s1_playing_q, s1_multi_q, s1_loop_q;
  logic [VOL_BITS-1:0]  s1_vol_q;

  logic advance, step;

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign step       = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_first_lvl_q  <= first_level_i;
      s1_second_lvl_q <= second_level_i;
      s1_now_q        <= now_us_i;
      s1_playing_q    <= is_playing_i;
      s1_multi_q      <= multi_list_mode_i;
      s1_loop_q       <= loop_now_i;
      s1_vol_q        <= volume_now_i;
    end
  end

  // classification
  btn_ctl_t   first_ctl, second_ctl;
  first_ev_e  ev1;
  second_ev_e ev2;

  always_comb begin
    first_ctl.step         = step;
    first_ctl.pressed      = active_low_q ? !s1_first_lvl_q : s1_first_lvl_q;
    first_ctl.now          = s1_now_q;
    first_ctl.hold_time    = hold_time_q;
    first_ctl.click_window = click_window_q;
    second_ctl             = first_ctl;
    second_ctl.pressed     = active_low_q ? !s1_second_lvl_q : s1_second_lvl_q;
  end

  tbgc_first_btn u_first (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (first_ctl),
    .playing_i (s1_playing_q),
    .event_o   (ev1)
  );

  tbgc_second_btn u_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (second_ctl),
    .multi_i (s1_multi_q),
    .event_o (ev2)
  );

  // result register
  logic                out_valid_q;
  logic [2:0]          ev1_q;
  logic [1:0]          ev2_q;
  logic [VOL_BITS-1:0] vol_next_q;
  logic                loop_next_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      ev1_q       <= ev1;
      ev2_q       <= ev2;
      vol_next_q  <= (ev1 == EV1_HOLD) ? step_volume(s1_vol_q) : s1_vol_q;
      loop_next_q <= (ev2 == EV2_LOOP) ? !s1_loop_q : s1_loop_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign first_event_o  = ev1_q;
  assign second_event_o = ev2_q;
  assign volume_next_o  = vol_next_q;
  assign loop_next_o    = loop_next_q;

endmodule
